// ----- rtl/rfcc_pkg.sv -----
package rfcc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CRC_W-1:0] CRC_SEED = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [LEN_W-1:0] INDEX_MAX = 9'd511;

  // frame kind register codes
  localparam logic [KIND_W-1:0] KIND_READ_REQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ_RESP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE_REQ = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EXCEPTION = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CRC_ERROR = 2'd2;

  // lengths include the two crc bytes
  localparam logic [LEN_W-1:0] LEN_READ_REQ   = 9'd8;
  localparam logic [LEN_W-1:0] LEN_READ_RESP  = 9'd5;
  localparam logic [LEN_W-1:0] LEN_WRITE_REQ  = 9'd9;
  localparam logic [LEN_W-1:0] LEN_EXCEPTION  = 9'd5;
  localparam logic [LEN_W-1:0] MIN_FRAME_LEN  = 9'd5;

  // position of the byte count field
  localparam logic [LEN_W-1:0] COUNT_POS_READ_RESP = 9'd2;
  localparam logic [LEN_W-1:0] COUNT_POS_WRITE_REQ = 9'd6;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   station_addr;
    logic [BYTE_W-1:0]   func_code;
    logic [LEN_W-1:0]    frame_length;
  } out_item_t;

  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/rfcc_frame_tracker.sv -----
module rfcc_frame_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  rfcc_pkg::in_item_t               item,
  input  logic                             cfg_we,
  input  logic [rfcc_pkg::KIND_W-1:0]      cfg_wdata,
  output logic                             res_load,
  output rfcc_pkg::out_item_t              res_item
);
  import rfcc_pkg::*;

  logic [KIND_W-1:0] frame_kind;
  logic [CRC_W-1:0]  crc_acc;
  logic [LEN_W-1:0]  byte_index;
  logic [LEN_W-1:0]  expected_length;
  logic [CRC_W-1:0]  received_crc;
  logic [BYTE_W-1:0] addr_hold;
  logic [BYTE_W-1:0] func_hold;

  logic [CRC_W-1:0]  crc_acc_next;
  logic [LEN_W-1:0]  byte_index_next;
  logic [LEN_W-1:0]  expected_length_next;
  logic [CRC_W-1:0]  received_crc_next;
  logic [BYTE_W-1:0] addr_hold_next;
  logic [BYTE_W-1:0] func_hold_next;
  logic [LEN_W:0]    pos_ext;
  logic [LEN_W:0]    exp_ext;
  logic [BYTE_W-1:0] b;

  always_comb begin
    b                    = item.rx_byte;
    expected_length_next = expected_length;
    addr_hold_next       = addr_hold;
    func_hold_next       = func_hold;

    if (byte_index == '0) begin
      case (frame_kind)
        KIND_READ_REQ:  expected_length_next = LEN_READ_REQ;
        KIND_READ_RESP: expected_length_next = LEN_READ_RESP;
        KIND_WRITE_REQ: expected_length_next = LEN_WRITE_REQ;
        default:        expected_length_next = LEN_EXCEPTION;
      endcase
      addr_hold_next = b;
    end else if (byte_index == 9'd1) begin
      func_hold_next = b;
    end

    // the byte count field stretches the frame
    if (frame_kind == KIND_READ_RESP && byte_index == COUNT_POS_READ_RESP) begin
      expected_length_next = LEN_READ_RESP + {1'b0, b};
    end
    if (frame_kind == KIND_WRITE_REQ && byte_index == COUNT_POS_WRITE_REQ) begin
      expected_length_next = LEN_WRITE_REQ + {1'b0, b};
    end

    pos_ext           = {1'b0, byte_index};
    exp_ext           = {1'b0, expected_length_next};
    crc_acc_next      = crc_acc;
    received_crc_next = received_crc;
    if (pos_ext + 10'd2 < exp_ext) begin
      crc_acc_next = crc_step(crc_acc, b);
    end else if (pos_ext + 10'd2 == exp_ext) begin
      received_crc_next = {received_crc[15:8], b};
    end else if (pos_ext + 10'd1 == exp_ext) begin
      received_crc_next = {b, received_crc[7:0]};
    end

    // saturate rather than wrap
    byte_index_next = (byte_index != INDEX_MAX) ? byte_index + 9'd1 : byte_index;

    if (byte_index_next < expected_length_next) begin
      res_item.status = STATUS_SHORT;
    end else if (received_crc_next == crc_acc_next) begin
      res_item.status = STATUS_OK;
    end else begin
      res_item.status = STATUS_CRC_ERROR;
    end
    res_item.station_addr = addr_hold_next;
    res_item.func_code    = func_hold_next;
    res_item.frame_length = expected_length_next;
    res_load              = accept & item.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_kind      <= KIND_READ_REQ;
      crc_acc         <= CRC_SEED;
      byte_index      <= '0;
      expected_length <= '0;
      received_crc    <= '0;
      addr_hold       <= '0;
      func_hold       <= '0;
    end else begin
      if (cfg_we) begin
        frame_kind <= cfg_wdata;
      end
      if (accept) begin
        if (item.last_byte) begin
          // frame done: start afresh
          crc_acc         <= CRC_SEED;
          byte_index      <= '0;
          expected_length <= '0;
          received_crc    <= '0;
          addr_hold       <= '0;
          func_hold       <= '0;
        end else begin
          crc_acc         <= crc_acc_next;
          byte_index      <= byte_index_next;
          expected_length <= expected_length_next;
          received_crc    <= received_crc_next;
          addr_hold       <= addr_hold_next;
          func_hold       <= func_hold_next;
        end
      end
    end
  end

endmodule

// ----- rtl/rfcc_out_buf.sv -----
module rfcc_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  rfcc_pkg::out_item_t load_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output rfcc_pkg::out_item_t out_item
);
  import rfcc_pkg::*;

  logic      main_valid;
  out_item_t main_item;
  logic      skid_valid;
  out_item_t skid_item;
  logic      pop;

  assign pop       = main_valid & ~out_stall;
  assign out_valid = main_valid;
  assign out_item  = main_item;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= load;
      end
    end else if (load) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_item <= skid_item;
      end else if (load) begin
        main_item <= load_item;
      end
    end else if (load) begin
      // park the item in the skid stage while the main one waits
      if (main_valid) begin
        skid_item <= load_item;
      end else begin
        main_item <= load_item;
      end
    end
  end

endmodule

// ----- rtl/rtu_frame_crc_checker_core.sv -----
// Frame checker for received RTU bytes: accepts one byte item per clock
// while byte_stall is low; a byte marked last yields one result. The cycle
// is set by the eight-bit CRC-16 step (reflected 0xA001) and the length and
// CRC compare that follow it, all between the frame state registers and the
// result register. A two-entry result buffer keeps bytes flowing while a
// result waits; byte_stall rises only when both entries are held. The user
// writes the frame kind register only while no item is in flight; the block
// does not check it. A mid-frame change applies from the next byte.
module rtu_frame_crc_checker_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  rfcc_pkg::in_item_t          byte_item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output rfcc_pkg::out_item_t         result_item,
  input  logic                        cfg_we,
  input  logic [rfcc_pkg::KIND_W-1:0] cfg_wdata
);
  import rfcc_pkg::*;

  logic      accept;
  logic      res_load;
  out_item_t res_item;
  logic      buf_full;

  assign byte_stall = buf_full;
  assign accept     = byte_valid & ~buf_full;

  rfcc_frame_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (byte_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_load  (res_load),
    .res_item  (res_item)
  );

  rfcc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .load_item (res_item),
    .full      (buf_full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_item  (result_item)
  );

`ifndef ASSERT_OFF
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && byte_item.last_byte |=> result_valid)
    else $error("last byte accepted but no result held");

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid)
    else $error("byte input stalled with no result waiting");

  a_length_floor: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.frame_length >= MIN_FRAME_LEN)
    else $error("result frame length below minimum");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import rfcc_pkg::*;

  logic      clk;
  logic      rst;
  logic      byte_valid;
  logic      byte_stall;
  in_item_t  byte_item;
  logic      result_valid;
  logic      result_stall;
  out_item_t result_item;
  logic      cfg_we;
  logic [KIND_W-1:0] cfg_wdata;

  rtu_frame_crc_checker_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // frame checker state as predicted by the testbench
  logic [KIND_W-1:0] kind_reg;
  logic [CRC_W-1:0]  crc_run;
  logic [CRC_W-1:0]  crc_rx;
  logic [BYTE_W-1:0] addr_seen;
  logic [BYTE_W-1:0] func_seen;
  int                byte_pos;
  int                frame_len;

  out_item_t   verdict_q[$];
  logic [7:0]  frame_bytes[$];
  int          error_count = 0;
  int          bytes_sent = 0;
  bit          tx_gaps = 0;
  bit          rx_gaps = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [CRC_W-1:0] crc16_add(input logic [CRC_W-1:0] c,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic clear_frame_model();
    crc_run   = CRC_SEED;
    crc_rx    = '0;
    addr_seen = '0;
    func_seen = '0;
    byte_pos  = 0;
    frame_len = 0;
  endtask

  // advance the predicted frame state by one accepted byte
  task automatic track_byte(input in_item_t it);
    out_item_t v;
    int p;
    p = byte_pos;
    if (p == 0) begin
      case (kind_reg)
        KIND_READ_REQ:  frame_len = LEN_READ_REQ;
        KIND_READ_RESP: frame_len = LEN_READ_RESP;
        KIND_WRITE_REQ: frame_len = LEN_WRITE_REQ;
        default:        frame_len = LEN_EXCEPTION;
      endcase
      addr_seen = it.rx_byte;
    end else if (p == 1) begin
      func_seen = it.rx_byte;
    end
    if (kind_reg == KIND_READ_RESP && p == COUNT_POS_READ_RESP)
      frame_len = int'(LEN_READ_RESP) + int'(it.rx_byte);
    if (kind_reg == KIND_WRITE_REQ && p == COUNT_POS_WRITE_REQ)
      frame_len = int'(LEN_WRITE_REQ) + int'(it.rx_byte);

    if (p + 2 < frame_len) begin
      crc_run = crc16_add(crc_run, it.rx_byte);
    end else if (p + 2 == frame_len) begin
      crc_rx[7:0] = it.rx_byte;
    end else if (p + 1 == frame_len) begin
      crc_rx[15:8] = it.rx_byte;
    end

    if (byte_pos < int'(INDEX_MAX)) byte_pos++;

    if (it.last_byte) begin
      if (byte_pos < frame_len) v.status = STATUS_SHORT;
      else if (crc_rx == crc_run) v.status = STATUS_OK;
      else v.status = STATUS_CRC_ERROR;
      v.station_addr = addr_seen;
      v.func_code    = func_seen;
      v.frame_length = frame_len[LEN_W-1:0];
      verdict_q.push_back(v);
      clear_frame_model();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_verdict(input out_item_t got);
    out_item_t want;
    if (verdict_q.size() == 0) begin
      report_mismatch($sformatf("result with none pending: status %0d addr %h func %h len %0d",
                                got.status, got.station_addr, got.func_code,
                                got.frame_length));
    end else begin
      want = verdict_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.station_addr !== want.station_addr)
        report_mismatch($sformatf("station_addr %h, want %h", got.station_addr,
                                  want.station_addr));
      if (got.func_code !== want.func_code)
        report_mismatch($sformatf("func_code %h, want %h", got.func_code, want.func_code));
      if (got.frame_length !== want.frame_length)
        report_mismatch($sformatf("frame_length %0d, want %0d", got.frame_length,
                                  want.frame_length));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_verdict(result_item);
  end

  // receiver stall: long hold-offs first, then random bursts
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 14);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    in_item_t it;
    it.rx_byte   = b;
    it.last_byte = is_last;
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
    track_byte(it);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // overwrite the two trailing bytes with the crc of everything before them
  function automatic void seal_crc();
    logic [CRC_W-1:0] c;
    int n;
    n = frame_bytes.size();
    c = CRC_SEED;
    for (int i = 0; i < n - 2; i++) c = crc16_add(c, frame_bytes[i]);
    frame_bytes[n-2] = c[7:0];
    frame_bytes[n-1] = c[15:8];
  endfunction

  task automatic build_frame(input logic [KIND_W-1:0] kind, input int count);
    int hdr;
    frame_bytes.delete();
    case (kind)
      KIND_READ_REQ:  hdr = 6;
      KIND_READ_RESP: hdr = 3 + count;
      KIND_WRITE_REQ: hdr = 7 + count;
      default:        hdr = 3;
    endcase
    for (int i = 0; i < hdr; i++) frame_bytes.push_back(8'($urandom));
    if (kind == KIND_READ_RESP) frame_bytes[COUNT_POS_READ_RESP] = 8'(count);
    if (kind == KIND_WRITE_REQ) frame_bytes[COUNT_POS_WRITE_REQ] = 8'(count);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'h00);
    seal_crc();
  endtask

  // drop valid, drain every pending result and let the pipeline settle
  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame_kind(input logic [KIND_W-1:0] kind);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= kind;
    @(posedge clk);
    cfg_we   <= 1'b0;
    kind_reg = kind;
  endtask

  task automatic test_read_request();
    build_frame(KIND_READ_REQ, 0);
    frame_bytes[0] = 8'h00;
    frame_bytes[1] = 8'hFF;
    seal_crc();
    send_frame();
    build_frame(KIND_READ_REQ, 0);
    frame_bytes[0] = 8'hFF;
    frame_bytes[1] = 8'h00;
    seal_crc();
    frame_bytes[6] ^= 8'h01;
    send_frame();
  endtask

  task automatic test_short_frames();
    // a lone byte leaves the function code unseen
    send_byte(8'hA5, 1'b1);
    build_frame(KIND_READ_REQ, 0);
    send_byte(frame_bytes[0], 1'b0);
    send_byte(frame_bytes[1], 1'b0);
    send_byte(frame_bytes[2], 1'b1);
  endtask

  task automatic test_read_response();
    set_frame_kind(KIND_READ_RESP);
    build_frame(KIND_READ_RESP, 0);
    send_frame();
    // ends before the count byte
    send_byte(8'h11, 1'b0);
    send_byte(8'h03, 1'b1);
  endtask

  task automatic test_write_request();
    set_frame_kind(KIND_WRITE_REQ);
    build_frame(KIND_WRITE_REQ, 1);
    send_frame();
    build_frame(KIND_WRITE_REQ, 4);
    while (frame_bytes.size() > 4) void'(frame_bytes.pop_back());
    send_frame();
  endtask

  task automatic test_exception();
    set_frame_kind(KIND_EXCEPTION);
    build_frame(KIND_EXCEPTION, 0);
    send_frame();
    // trailing bytes past the frame are ignored
    build_frame(KIND_EXCEPTION, 0);
    frame_bytes.push_back(8'h5A);
    frame_bytes.push_back(8'hC3);
    send_frame();
  endtask

  task automatic test_kind_switch();
    set_frame_kind(KIND_READ_REQ);
    send_byte(8'h21, 1'b0);
    send_byte(8'h03, 1'b0);
    set_frame_kind(KIND_READ_RESP);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h9B, 1'b1);
  endtask

  task automatic test_counter_saturation();
    set_frame_kind(KIND_READ_RESP);
    build_frame(KIND_READ_RESP, 255);
    repeat (260) frame_bytes.push_back(8'($urandom));
    send_frame();
    // longest length, cut short one byte after the count byte
    set_frame_kind(KIND_WRITE_REQ);
    build_frame(KIND_WRITE_REQ, 255);
    while (frame_bytes.size() > 8) void'(frame_bytes.pop_back());
    send_frame();
  endtask

  task automatic test_backpressure();
    set_frame_kind(KIND_READ_REQ);
    hold_left = 300;
    repeat (40) send_byte(8'($urandom), 1'b1);
  endtask

  task automatic test_random_frames();
    logic [KIND_W-1:0] kinds[5];
    int count;
    int sel;
    int n;
    int target;
    kinds = '{KIND_EXCEPTION, KIND_READ_REQ, KIND_WRITE_REQ, KIND_READ_RESP, KIND_READ_REQ};
    kinds[4] = KIND_W'($urandom_range(0, 3));
    for (int ph = 0; ph < 5; ph++) begin
      set_frame_kind(kinds[ph]);
      tx_gaps = (ph == 0 || ph == 1 || ph == 3);
      rx_gaps = (ph == 0 || ph == 2 || ph == 3);
      target = bytes_sent + 20;
      while (bytes_sent < target) begin
        count = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        build_frame(kind_reg, count);
        sel = $urandom_range(0, 19);
        n = frame_bytes.size();
        if (sel < 2) begin
          frame_bytes[$urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end else if (sel < 4) begin
          n = $urandom_range(1, n - 1);
          while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
        end else if (sel == 4) begin
          repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
        end else if (sel == 5) begin
          frame_bytes.delete();
          repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
        end
        send_frame();
      end
    end
    tx_gaps = 0;
    rx_gaps = 0;
  endtask

  initial begin
    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_item  = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    kind_reg   = KIND_READ_REQ;
    clear_frame_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_read_request();
    test_short_frames();
    test_read_response();
    test_write_request();
    test_exception();
    test_kind_switch();
    test_counter_saturation();
    test_backpressure();
    test_random_frames();

    wait_idle();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
